// ----- hw/rtl/primitive_index_assembler_assert.svh -----
// Assertion macros for the primitive index assembler checks
`ifndef PRIMITIVE_INDEX_ASSEMBLER_ASSERT_SVH
`define PRIMITIVE_INDEX_ASSEMBLER_ASSERT_SVH

// same-cycle implication
`define PIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pia_pkg.sv -----
`default_nettype none

package pia_pkg;

  localparam int FIELD_WIDTH     = 32;
  localparam int INDEX_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH      = 4;

  typedef logic [FIELD_WIDTH-1:0] field_t;

  typedef enum logic [2:0] {
    MODE_POINTS    = 3'd0,
    MODE_LINES     = 3'd1,
    MODE_LOOP      = 3'd2,
    MODE_STRIP     = 3'd3,
    MODE_TRIS      = 3'd4,
    MODE_TRI_STRIP = 3'd5,
    MODE_FAN       = 3'd6,
    MODE_TRIS_ALT  = 3'd7
  } mode_t;

  localparam mode_t MODE_RESET = MODE_TRIS;

  typedef enum logic [1:0] {
    KIND_FACE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_SHORT = 2'd2
  } kind_t;

  localparam logic [1:0] CORNERS_NONE  = 2'd0;
  localparam logic [1:0] CORNERS_POINT = 2'd1;
  localparam logic [1:0] CORNERS_LINE  = 2'd2;
  localparam logic [1:0] CORNERS_TRI   = 2'd3;

  typedef struct packed {
    field_t      corner_a;
    field_t      corner_b;
    field_t      corner_c;
    logic [1:0]  corner_count;
    kind_t       result_kind;
    logic        final_result;
  } res_t;

  // results of one input beat, in order: r0 first
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } step_t;

  function automatic res_t mk_face(field_t a, field_t b, field_t c, logic [1:0] cnt);
    res_t r;
    r.corner_a     = a;
    r.corner_b     = b;
    r.corner_c     = c;
    r.corner_count = cnt;
    r.result_kind  = KIND_FACE;
    r.final_result = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_mark(kind_t kind);
    res_t r;
    r.corner_a     = '0;
    r.corner_b     = '0;
    r.corner_c     = '0;
    r.corner_count = CORNERS_NONE;
    r.result_kind  = kind;
    r.final_result = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pia_stream_if.sv -----
`default_nettype none

interface pia_in_if;
  logic                       valid;
  logic                       ready;
  logic [pia_pkg::FIELD_WIDTH-1:0] vertex_index;
  logic                       stream_end;

  modport source (output valid, vertex_index, stream_end, input ready);
  modport sink   (input valid, vertex_index, stream_end, output ready);
endinterface

interface pia_out_if;
  logic                       valid;
  logic                       ready;
  logic [pia_pkg::FIELD_WIDTH-1:0] corner_a;
  logic [pia_pkg::FIELD_WIDTH-1:0] corner_b;
  logic [pia_pkg::FIELD_WIDTH-1:0] corner_c;
  logic [1:0]                 corner_count;
  logic [1:0]                 result_kind;
  logic                       final_result;

  modport source (output valid, corner_a, corner_b, corner_c, corner_count, result_kind,
                  final_result, input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, corner_count, result_kind,
                  final_result, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/primitive_index_assembler.sv -----
// An accepted index beat is registered in the input stage, then queued.
// Throughput: one index beat per cycle while the queue has two free slots;
// a line loop's last index yields two result beats for the 4-entry queue.
// Reset (rst_n low, synchronous): mode returns to triangle list, stream
// position, phase and parity clear, input stage and result queue empty.
`default_nettype none

module primitive_index_assembler #(
  parameter int INDEX_WIDTH = pia_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pia_in_if.sink          in_ch,
  pia_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata
);

  pia_pkg::mode_t         mode_r;
  logic                   s1_valid_r;
  logic [INDEX_WIDTH-1:0] s1_index_r;
  logic                   s1_end_r;
  logic                   advance, room;
  pia_pkg::step_t         step;
  pia_pkg::res_t          head;

  assign advance     = s1_valid_r && room;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pia_pkg::MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= pia_pkg::mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_index_r <= in_ch.vertex_index[INDEX_WIDTH-1:0];
      s1_end_r   <= in_ch.stream_end;
    end
  end

  pia_face_gen #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_face_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_r),
    .vertex  (s1_index_r),
    .last    (s1_end_r),
    .advance (advance),
    .step    (step)
  );

  pia_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .step      (step),
    .room      (room),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .head      (head)
  );

  assign out_ch.corner_a     = head.corner_a;
  assign out_ch.corner_b     = head.corner_b;
  assign out_ch.corner_c     = head.corner_c;
  assign out_ch.corner_count = head.corner_count;
  assign out_ch.result_kind  = head.result_kind;
  assign out_ch.final_result = head.final_result;

endmodule

`default_nettype wire

// ----- hw/rtl/pia_face_gen.sv -----
`default_nettype none

module pia_face_gen #(
  parameter int INDEX_WIDTH = pia_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pia_pkg::mode_t         mode,
  input  wire logic [INDEX_WIDTH-1:0] vertex,
  input  wire logic                   last,
  input  wire logic                   advance,
  output pia_pkg::step_t              step
);

  logic [INDEX_WIDTH-1:0] first_r, older_r, newer_r;
  logic [1:0]             pos_r, phase_r;
  logic                   odd_r;

  logic [1:0]             cnt, need, phase_nxt, n;
  logic [INDEX_WIDTH-1:0] first_eff;
  logic                   f0v, f1v;
  pia_pkg::res_t          f0, f1;
  pia_pkg::field_t        v_w, first_w, older_w, newer_w;

  assign v_w     = pia_pkg::field_t'(vertex);
  assign first_w = pia_pkg::field_t'(first_eff);
  assign older_w = pia_pkg::field_t'(older_r);
  assign newer_w = pia_pkg::field_t'(newer_r);

  assign cnt       = (pos_r == 2'd3) ? 2'd3 : pos_r + 2'd1;
  assign first_eff = (pos_r == 2'd0) ? vertex : first_r;

  always_comb begin
    f0v       = 1'b0;
    f1v       = 1'b0;
    f0        = pia_pkg::mk_face('0, '0, '0, pia_pkg::CORNERS_NONE);
    f1        = f0;
    phase_nxt = 2'd0;
    need      = pia_pkg::CORNERS_TRI;
    unique case (mode) inside
      pia_pkg::MODE_POINTS: begin
        need = pia_pkg::CORNERS_POINT;
        f0v  = 1'b1;
        f0   = pia_pkg::mk_face(v_w, '0, '0, pia_pkg::CORNERS_POINT);
      end
      pia_pkg::MODE_LINES: begin
        need = pia_pkg::CORNERS_LINE;
        if (phase_r != 2'd0) begin
          f0v = 1'b1;
          f0  = pia_pkg::mk_face(newer_w, v_w, '0, pia_pkg::CORNERS_LINE);
        end else begin
          phase_nxt = 2'd1;
        end
      end
      pia_pkg::MODE_LOOP, pia_pkg::MODE_STRIP: begin
        need = pia_pkg::CORNERS_LINE;
        f0v  = (pos_r != 2'd0);
        f0   = pia_pkg::mk_face(newer_w, v_w, '0, pia_pkg::CORNERS_LINE);
        f1v  = (mode == pia_pkg::MODE_LOOP) && last && (cnt >= 2'd2);
        f1   = pia_pkg::mk_face(v_w, first_w, '0, pia_pkg::CORNERS_LINE);
      end
      pia_pkg::MODE_TRI_STRIP: begin
        f0v = (pos_r >= 2'd2);
        f0  = odd_r ? pia_pkg::mk_face(newer_w, older_w, v_w, pia_pkg::CORNERS_TRI)
                    : pia_pkg::mk_face(older_w, newer_w, v_w, pia_pkg::CORNERS_TRI);
      end
      pia_pkg::MODE_FAN: begin
        f0v = (pos_r >= 2'd2);
        f0  = pia_pkg::mk_face(first_w, newer_w, v_w, pia_pkg::CORNERS_TRI);
      end
      default: begin
        if (phase_r >= 2'd2) begin
          f0v = 1'b1;
          f0  = pia_pkg::mk_face(older_w, newer_w, v_w, pia_pkg::CORNERS_TRI);
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
    endcase
  end

  always_comb begin
    n       = {1'b0, f0v} + {1'b0, f1v};
    step.r0 = f0v ? f0 : f1;
    step.r1 = f1;
    if (last) begin
      if (n == 2'd0) begin
        step.r0 = pia_pkg::mk_mark((cnt >= need) ? pia_pkg::KIND_END : pia_pkg::KIND_SHORT);
        n       = 2'd1;
      end else if (n == 2'd2) begin
        step.r1.final_result = 1'b1;
      end else begin
        step.r0.final_result = 1'b1;
      end
    end
    step.n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      older_r <= '0;
      newer_r <= '0;
      pos_r   <= 2'd0;
      phase_r <= 2'd0;
      odd_r   <= 1'b0;
    end else if (advance) begin
      first_r <= first_eff;
      older_r <= newer_r;
      newer_r <= vertex;
      pos_r   <= last ? 2'd0 : cnt;
      phase_r <= last ? 2'd0 : phase_nxt;
      odd_r   <= last ? 1'b0 : ~odd_r;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pia_result_fifo.sv -----
`default_nettype none

module pia_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pia_pkg::step_t step,
  output logic                room,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output pia_pkg::res_t       head
);

  localparam int DEPTH = pia_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pia_pkg::res_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       n_push;
  logic             pop;

  assign room      = (count_r <= CNT_W'(DEPTH - 2));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign head      = mem[rd_ptr_r];
  assign n_push    = push ? step.n : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr_r] <= step.r0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pia_checker.sv -----
`default_nettype none
`include "primitive_index_assembler_assert.svh"

module pia_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_corner_a,
  input wire logic [31:0] out_corner_b,
  input wire logic [31:0] out_corner_c,
  input wire logic [1:0]  out_corner_count,
  input wire logic [1:0]  out_result_kind,
  input wire logic        out_final_result
);

  logic [100:0] out_beat;
  logic         stalled, is_face, is_mark, is_point, has_corners, mark_ok, bc_zero;

  assign out_beat    = {out_corner_a, out_corner_b, out_corner_c, out_corner_count,
                        out_result_kind, out_final_result};
  assign stalled     = out_valid && !out_ready;
  assign is_face     = out_valid && (out_result_kind == pia_pkg::KIND_FACE);
  assign is_mark     = out_valid && (out_result_kind != pia_pkg::KIND_FACE);
  assign is_point    = out_valid && (out_corner_count == pia_pkg::CORNERS_POINT);
  assign has_corners = (out_corner_count != pia_pkg::CORNERS_NONE);
  assign bc_zero     = (out_corner_b == '0) && (out_corner_c == '0);
  assign mark_ok     = out_final_result && !has_corners && (out_corner_a == '0) && bc_zero;

  `PIA_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_beat), "beat changed in stall")
  `PIA_ASSERT_NOW(a_face_corners, is_face, has_corners, "face beat without corners")
  `PIA_ASSERT_NOW(a_mark_shape, is_mark, mark_ok, "marker beat malformed")
  `PIA_ASSERT_NOW(a_point_zero, is_point, bc_zero, "point beat has extra corners")

endmodule

bind primitive_index_assembler pia_checker u_pia_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_corner_a     (out_ch.corner_a),
  .out_corner_b     (out_ch.corner_b),
  .out_corner_c     (out_ch.corner_c),
  .out_corner_count (out_ch.corner_count),
  .out_result_kind  (out_ch.result_kind),
  .out_final_result (out_ch.final_result)
);

`default_nettype wire
